FILE: sv/nhs_pkg.sv
`default_nettype none
package nhs_pkg;

   localparam int FRAC_BITS_DEF       = 16;
   localparam int LOG_TABLE_DEPTH_DEF = 64;
   localparam int NUM_COLS            = 6;

   localparam logic [2:0] ROW_STRESS = 3'd0;
   localparam logic [2:0] ROW_LAST   = 3'd6;

   localparam logic CSR_SHEAR_MODULUS = 1'b0;
   localparam logic CSR_LAME_LAMBDA   = 1'b1;

   // Tensor indices of the Voigt components xx, yy, zz, xy, yz, xz.
   localparam logic [1:0] VOIGT_I [NUM_COLS] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};
   localparam logic [1:0] VOIGT_J [NUM_COLS] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

   typedef struct packed {
      logic [NUM_COLS-1:0][31:0] b;
      logic [30:0]               j;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] row;
      item_type   item;
   } issue_type;

   // Voigt slot of the symmetric component b_ik.
   function automatic logic [2:0] comp_slot(input logic [1:0] i, input logic [1:0] k);
      logic [2:0] s;
      s = 3'(i) + 3'(k);
      if (i == k) begin
         return 3'(i);
      end else if (s == 3'd1) begin
         return 3'd3;
      end else if (s == 3'd3) begin
         return 3'd4;
      end else begin
         return 3'd5;
      end
   endfunction

   // Round half up by a right shift of s bits, then saturate to 32 bits.
   function automatic logic signed [31:0] rnd_sat(input logic signed [71:0] v, input int s);
      logic signed [71:0] h;
      logic signed [71:0] t;
      h = (s > 0) ? (72'sd1 <<< (s - 1)) : 72'sd0;
      t = (v + h) >>> s;
      if (t > 72'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (t < -72'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return t[31:0];
      end
   endfunction

endpackage
`default_nettype wire

FILE: sv/nhs_ln.sv
`default_nettype none
module nhs_ln #(
   parameter int FRAC_BITS       = nhs_pkg::FRAC_BITS_DEF,
   parameter int LOG_TABLE_DEPTH = nhs_pkg::LOG_TABLE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic [3:0]         en,
   input  wire logic [30:0]        j,
   output logic signed [31:0]      lnq
);

   localparam int LW = $clog2(LOG_TABLE_DEPTH + 1);
   localparam int TW = 30 + LW;

   typedef logic [29:0] tab_arr_type [0:LOG_TABLE_DEPTH];

   // Entry k holds ln(1 + k/D) in Q30, taken as ln(D + k) - ln(D).
   function automatic tab_arr_type mk_tab();
      tab_arr_type t;
      real         x;
      int          k;
      for (k = 0; k <= LOG_TABLE_DEPTH; k++) begin
         x = ($ln(real'(LOG_TABLE_DEPTH + k)) - $ln(real'(LOG_TABLE_DEPTH)))
             * 1073741824.0;
         t[k] = 30'($rtoi(x + 0.5));
      end
      return t;
   endfunction

   localparam tab_arr_type LN_TAB = mk_tab();
   localparam logic [29:0] LN2_Q30 = LN_TAB[LOG_TABLE_DEPTH];

   logic [30:0]        jv_ff, jv_in;
   logic [4:0]         p_ff, p_in;
   logic [LW-1:0]      idx_ff, idx_in;
   logic [29:0]        rem_ff, rem_in;
   logic signed [6:0]  e2_ff, e2_in, e3_ff;
   logic [29:0]        lo_ff, lo_in;
   logic [29:0]        ip_ff, ip_in;
   logic signed [31:0] lnq_ff, lnq_in;

   always_comb begin
      jv_in = (j == 31'd0) ? 31'd1 : j;
      p_in  = 5'd0;
      for (int b = 0; b < 31; b++) begin
         if (jv_in[b]) begin
            p_in = 5'(b);
         end
      end
   end

   always_comb begin
      logic [30:0]   sh;
      logic [TW-1:0] t;
      logic [TW-1:0] ti;
      sh     = jv_ff << (5'd30 - p_ff);
      t      = TW'(sh[29:0]) * TW'(LOG_TABLE_DEPTH);
      ti     = t >> 30;
      if (ti >= TW'(LOG_TABLE_DEPTH)) begin
         ti = TW'(LOG_TABLE_DEPTH - 1);
      end
      idx_in = ti[LW-1:0];
      rem_in = t[29:0];
      e2_in  = $signed({2'b00, p_ff}) - 7'(FRAC_BITS);
   end

   always_comb begin
      logic [29:0] hi;
      logic [59:0] pr;
      lo_in = LN_TAB[idx_ff];
      hi    = LN_TAB[idx_ff + LW'(1)];
      pr    = 60'(hi - lo_in) * 60'(rem_ff);
      ip_in = pr[59:30];
   end

   always_comb begin
      logic signed [39:0] ln30;
      ln30   = 40'(e3_ff) * $signed({10'd0, LN2_Q30}) + $signed({10'd0, lo_ff})
             + $signed({10'd0, ip_ff});
      lnq_in = nhs_pkg::rnd_sat(72'(ln30), 30 - FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         jv_ff <= jv_in;
         p_ff  <= p_in;
      end
      if (en[1]) begin
         idx_ff <= idx_in;
         rem_ff <= rem_in;
         e2_ff  <= e2_in;
      end
      if (en[2]) begin
         lo_ff <= lo_in;
         ip_ff <= ip_in;
         e3_ff <= e2_ff;
      end
      if (en[3]) begin
         lnq_ff <= lnq_in;
      end
   end

   assign lnq = lnq_ff;

endmodule
`default_nettype wire

FILE: sv/nhs_seq.sv
`default_nettype none
module nhs_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire nhs_pkg::item_type in_item,
   input  wire logic              issue_ready,
   output nhs_pkg::issue_type     issue
);

   nhs_pkg::item_type item_ff, item_in;
   logic              hold_ff, hold_in;
   logic [2:0]        row_ff, row_in;
   logic              done;

   // The held point frees up in the cycle that its last row is issued.
   assign done     = hold_ff && issue_ready && (row_ff == nhs_pkg::ROW_LAST);
   assign in_ready = !hold_ff || done;

   always_comb begin
      item_in = item_ff;
      hold_in = hold_ff;
      row_in  = row_ff;
      if (hold_ff && issue_ready) begin
         row_in = row_ff + 3'd1;
         if (done) begin
            hold_in = 1'b0;
         end
      end
      if (in_valid && in_ready) begin
         item_in = in_item;
         hold_in = 1'b1;
         row_in  = nhs_pkg::ROW_STRESS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         row_ff  <= nhs_pkg::ROW_STRESS;
      end else begin
         hold_ff <= hold_in;
         row_ff  <= row_in;
      end
      item_ff <= item_in;
   end

   assign issue.valid = hold_ff;
   assign issue.row   = row_ff;
   assign issue.item  = item_ff;

   assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> row_ff <= nhs_pkg::ROW_LAST)
      else $error("row counter past last row");
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (hold_ff && row_ff == nhs_pkg::ROW_STRESS))
      else $error("accepted point does not start at the stress row");
   assert property (@(posedge clock) disable iff (reset)
      done |=> !hold_ff || row_ff == nhs_pkg::ROW_STRESS)
      else $error("sequencer did not release after last row");

endmodule
`default_nettype wire

FILE: sv/nhs_datapath.sv
`default_nettype none
module nhs_datapath #(
   parameter int FRAC_BITS       = nhs_pkg::FRAC_BITS_DEF,
   parameter int LOG_TABLE_DEPTH = nhs_pkg::LOG_TABLE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire nhs_pkg::issue_type   issue,
   output logic                      issue_ready,
   input  wire logic [30:0]          mu,
   input  wire logic signed [31:0]   lam,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [2:0]                out_row,
   output logic [5:0][31:0]          out_cols,
   output logic                      out_last
);

   localparam int NC = nhs_pkg::NUM_COLS;

   logic [6:1]       vld_ff;
   logic [7:1]       en;
   logic [2:0]       row_ff [6:1];
   logic signed [31:0] lnq;

   // Stage 1: raw products.
   logic signed [63:0] x1_ff [NC], x1_in [NC];
   logic signed [63:0] x2_ff [NC], x2_in [NC];
   logic signed [63:0] cr_ff [NC], cr_in [NC];
   logic               dg1_ff, dg1_in;
   logic signed [63:0] mjr_ff, mjr_in;
   logic signed [63:0] ljr_ff, ljr_in;
   logic [NC-1:0][31:0] b1_ff;
   // Stage 2: rounded products.
   logic signed [31:0] p1_ff [NC], p1_in [NC];
   logic signed [31:0] p2_ff [NC], p2_in [NC];
   logic signed [31:0] c2_ff [NC], c2_in [NC];
   logic signed [31:0] mj_ff, lj2_ff;
   logic [NC-1:0][31:0] b2_ff;
   // Stage 3: modulus products.
   logic signed [63:0] m1_ff [NC], m1_in [NC];
   logic signed [63:0] m2_ff [NC], m2_in [NC];
   logic signed [31:0] c3_ff [NC];
   logic signed [71:0] sr_ff [NC], sr_in [NC];
   logic signed [31:0] lj3_ff;
   // Stage 4: tangent entries and first stress terms.
   logic signed [31:0] tn4_ff [NC], tn4_in [NC];
   logic signed [31:0] t14_ff [NC], t14_in [NC];
   logic signed [31:0] lj4_ff;
   // Stage 5: volumetric product.
   logic signed [31:0] tn5_ff [NC];
   logic signed [31:0] t15_ff [NC];
   logic signed [63:0] t2r_ff, t2r_in;
   // Stage 6: output register.
   logic signed [31:0] o_ff [NC], o_in [NC];

   assign en[7] = out_ready;
   for (genvar k = 1; k <= 6; k++) begin : g_en
      assign en[k] = !vld_ff[k] || en[k+1];
   end
   assign issue_ready = en[1];

   always_comb begin
      logic [2:0]  rs;
      logic [1:0]  ti, tj, ck, cl;
      logic [31:0] bik, blj, bil, bkj, bkl;
      logic [30:0] jz;
      rs     = (issue.row == nhs_pkg::ROW_STRESS) ? 3'd0 : issue.row - 3'd1;
      ti     = nhs_pkg::VOIGT_I[rs];
      tj     = nhs_pkg::VOIGT_J[rs];
      dg1_in = (ti == tj);
      for (int n = 0; n < NC; n++) begin
         ck  = nhs_pkg::VOIGT_I[n];
         cl  = nhs_pkg::VOIGT_J[n];
         bik = issue.item.b[nhs_pkg::comp_slot(ti, ck)];
         blj = issue.item.b[nhs_pkg::comp_slot(cl, tj)];
         bil = issue.item.b[nhs_pkg::comp_slot(ti, cl)];
         bkj = issue.item.b[nhs_pkg::comp_slot(ck, tj)];
         bkl = issue.item.b[n];
         x1_in[n] = $signed(bik) * $signed(blj);
         x2_in[n] = $signed(bil) * $signed(bkj);
         cr_in[n] = lam * $signed(bkl);
      end
      // A zero j stands for the smallest positive value.
      jz     = (issue.item.j == 31'd0) ? 31'd1 : issue.item.j;
      mjr_in = $signed({1'b0, mu}) * $signed({1'b0, jz});
      ljr_in = lam * $signed({1'b0, jz});
   end

   always_comb begin
      for (int n = 0; n < NC; n++) begin
         p1_in[n] = nhs_pkg::rnd_sat(72'(x1_ff[n]), FRAC_BITS);
         p2_in[n] = nhs_pkg::rnd_sat(72'(x2_ff[n]), FRAC_BITS);
         c2_in[n] = dg1_ff ? nhs_pkg::rnd_sat(72'(cr_ff[n]), FRAC_BITS + 1) : 32'sd0;
      end
   end

   always_comb begin
      logic signed [32:0] bm1;
      for (int n = 0; n < NC; n++) begin
         m1_in[n] = $signed({1'b0, mu}) * p1_ff[n];
         m2_in[n] = $signed({1'b0, mu}) * p2_ff[n];
         if (n < 3) begin
            bm1      = $signed({b2_ff[n][31], b2_ff[n]}) - (33'sd1 <<< FRAC_BITS);
            sr_in[n] = 72'(mj_ff * bm1);
         end else begin
            sr_in[n] = 72'(mj_ff * $signed(b2_ff[n]));
         end
      end
   end

   always_comb begin
      logic signed [31:0] a;
      for (int n = 0; n < NC; n++) begin
         a         = nhs_pkg::rnd_sat(72'(m1_ff[n]) + 72'(m2_ff[n]), FRAC_BITS + 1);
         tn4_in[n] = nhs_pkg::rnd_sat(-72'(a) - 72'(c3_ff[n]), 0);
         t14_in[n] = nhs_pkg::rnd_sat(sr_ff[n], FRAC_BITS);
      end
      t2r_in = lj4_ff * lnq;
   end

   always_comb begin
      logic signed [31:0] t2;
      t2 = nhs_pkg::rnd_sat(72'(t2r_ff), FRAC_BITS);
      for (int n = 0; n < NC; n++) begin
         if (row_ff[5] != nhs_pkg::ROW_STRESS) begin
            o_in[n] = tn5_ff[n];
         end else if (n < 3) begin
            o_in[n] = nhs_pkg::rnd_sat(72'(t15_ff[n]) - 72'(t2), 0);
         end else begin
            o_in[n] = t15_ff[n];
         end
      end
   end

   nhs_ln #(
      .FRAC_BITS       (FRAC_BITS),
      .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
   ) u_ln (
      .clock (clock),
      .en    (en[4:1]),
      .j     (issue.item.j),
      .lnq   (lnq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[1]) vld_ff[1] <= issue.valid;
         for (int k = 2; k <= 6; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         row_ff[1] <= issue.row;
         x1_ff     <= x1_in;
         x2_ff     <= x2_in;
         cr_ff     <= cr_in;
         dg1_ff    <= dg1_in;
         mjr_ff    <= mjr_in;
         ljr_ff    <= ljr_in;
         b1_ff     <= issue.item.b;
      end
      if (en[2]) begin
         row_ff[2] <= row_ff[1];
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         c2_ff     <= c2_in;
         mj_ff     <= nhs_pkg::rnd_sat(72'(mjr_ff), FRAC_BITS);
         lj2_ff    <= nhs_pkg::rnd_sat(72'(ljr_ff), FRAC_BITS);
         b2_ff     <= b1_ff;
      end
      if (en[3]) begin
         row_ff[3] <= row_ff[2];
         m1_ff     <= m1_in;
         m2_ff     <= m2_in;
         c3_ff     <= c2_ff;
         sr_ff     <= sr_in;
         lj3_ff    <= lj2_ff;
      end
      if (en[4]) begin
         row_ff[4] <= row_ff[3];
         tn4_ff    <= tn4_in;
         t14_ff    <= t14_in;
         lj4_ff    <= lj3_ff;
      end
      if (en[5]) begin
         row_ff[5] <= row_ff[4];
         tn5_ff    <= tn4_ff;
         t15_ff    <= t14_ff;
         t2r_ff    <= t2r_in;
      end
      if (en[6]) begin
         row_ff[6] <= row_ff[5];
         o_ff      <= o_in;
      end
   end

   assign out_valid = vld_ff[6];
   assign out_row   = row_ff[6];
   assign out_last  = (row_ff[6] == nhs_pkg::ROW_LAST);
   for (genvar n = 0; n < NC; n++) begin : g_out
      assign out_cols[n] = o_ff[n];
   end

endmodule
`default_nettype wire

FILE: sv/neo_hookean_stress_and_tangent_unit.sv
// The stress row of a point leaves after the sequencer register and the six pipeline stages;
// the six tangent rows follow, one per cycle while rsp_ready is high.
// A new point is taken in the cycle that the last row of the previous one is issued.
// Back-pressure stalls only stages that hold a beat; empty stages keep filling.
// Reset is synchronous and active high: it empties the pipeline and sets both
// Lame constants to 1.0.
`default_nettype none
module neo_hookean_stress_and_tangent_unit #(
   parameter int FRAC_BITS       = nhs_pkg::FRAC_BITS_DEF,
   parameter int LOG_TABLE_DEPTH = nhs_pkg::LOG_TABLE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [31:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_b_xx,
   input  wire logic signed [31:0] req_b_yy,
   input  wire logic signed [31:0] req_b_zz,
   input  wire logic signed [31:0] req_b_xy,
   input  wire logic signed [31:0] req_b_yz,
   input  wire logic signed [31:0] req_b_xz,
   input  wire logic [30:0]        req_inv_jacobian,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_row_index,
   output logic signed [31:0]      rsp_col_xx,
   output logic signed [31:0]      rsp_col_yy,
   output logic signed [31:0]      rsp_col_zz,
   output logic signed [31:0]      rsp_col_xy,
   output logic signed [31:0]      rsp_col_yz,
   output logic signed [31:0]      rsp_col_xz,
   output logic                    rsp_last_row
);

   logic [30:0]        mu_ff, mu_in;
   logic signed [31:0] lam_ff, lam_in;
   nhs_pkg::item_type  item;
   nhs_pkg::issue_type issue;
   logic               issue_ready;
   logic [5:0][31:0]   cols;

   always_comb begin
      mu_in  = mu_ff;
      lam_in = lam_ff;
      if (csr_we) begin
         case (csr_index)
            nhs_pkg::CSR_SHEAR_MODULUS: mu_in  = csr_wdata[30:0];
            nhs_pkg::CSR_LAME_LAMBDA:   lam_in = $signed(csr_wdata);
            default:                    mu_in  = mu_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff  <= 31'd65536;
         lam_ff <= 32'sd65536;
      end else begin
         mu_ff  <= mu_in;
         lam_ff <= lam_in;
      end
   end

   assign item.b[0] = req_b_xx;
   assign item.b[1] = req_b_yy;
   assign item.b[2] = req_b_zz;
   assign item.b[3] = req_b_xy;
   assign item.b[4] = req_b_yz;
   assign item.b[5] = req_b_xz;
   assign item.j    = req_inv_jacobian;

   nhs_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_item     (item),
      .issue_ready (issue_ready),
      .issue       (issue)
   );

   nhs_datapath #(
      .FRAC_BITS       (FRAC_BITS),
      .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .issue       (issue),
      .issue_ready (issue_ready),
      .mu          (mu_ff),
      .lam         (lam_ff),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_row     (rsp_row_index),
      .out_cols    (cols),
      .out_last    (rsp_last_row)
   );

   assign rsp_col_xx = cols[0];
   assign rsp_col_yy = cols[1];
   assign rsp_col_zz = cols[2];
   assign rsp_col_xy = cols[3];
   assign rsp_col_yz = cols[4];
   assign rsp_col_xz = cols[5];

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_row) |-> rsp_row_index == nhs_pkg::ROW_LAST)
      else $error("last row flag on wrong row");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row_index <= nhs_pkg::ROW_LAST)
      else $error("row index out of range");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second point taken before rows were issued");

endmodule
`default_nettype wire

FILE: sim/tb_neo_hookean_stress_and_tangent_unit.sv
`timescale 1ns / 100ps
module tb_neo_hookean_stress_and_tangent_unit;
   import nhs_pkg::*;

   localparam int FB        = FRAC_BITS_DEF;
   localparam int LN_DEPTH  = LOG_TABLE_DEPTH_DEF;
   localparam int MAX_CYC   = 400000;

   typedef struct {
      logic signed [31:0] b [NUM_COLS];
      logic [30:0]        j;
   } point_t;

   typedef struct {
      logic [2:0]         row;
      logic signed [31:0] col [NUM_COLS];
      logic               last;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_index = CSR_SHEAR_MODULUS;
   logic [31:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_b [NUM_COLS];
   logic [30:0] req_inv_jacobian = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_row_index;
   logic signed [31:0] rsp_col [NUM_COLS];
   logic rsp_last_row;

   point_t pending_points [$];
   row_t   expected_rows [$];
   longint ln_table [LN_DEPTH + 1];
   longint model_mu = 65536;
   longint model_lam = 65536;
   int tx_idle = 0;
   int rx_idle = 0;
   int errors = 0;
   int points_done = 0;
   int rows_done = 0;
   int cycles = 0;

   initial begin
      foreach (req_b[n]) req_b[n] = '0;
   end

   always #1 clock = ~clock;

   neo_hookean_stress_and_tangent_unit u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_b_xx(req_b[0]), .req_b_yy(req_b[1]), .req_b_zz(req_b[2]),
      .req_b_xy(req_b[3]), .req_b_yz(req_b[4]), .req_b_xz(req_b[5]),
      .req_inv_jacobian(req_inv_jacobian),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_row_index(rsp_row_index),
      .rsp_col_xx(rsp_col[0]), .rsp_col_yy(rsp_col[1]), .rsp_col_zz(rsp_col[2]),
      .rsp_col_xy(rsp_col[3]), .rsp_col_yz(rsp_col[4]), .rsp_col_xz(rsp_col[5]),
      .rsp_last_row(rsp_last_row)
   );

   // floor(a*b / 2^60) for operands below 2^60.
   function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
      longint unsigned ah, al, bh, bl, mid;
      ah = a >> 32; al = a & 64'hffffffff;
      bh = b >> 32; bl = b & 64'hffffffff;
      mid = ah * bl + al * bh + ((al * bl) >> 32);
      return ((ah * bh) << 4) + (mid >> 28);
   endfunction

   // ln(1 + k/D) in Q30 from the atanh series.
   function automatic longint ln_point(longint unsigned k);
      longint unsigned d, q1, r, z, z2, p, sum;
      d = 2 * LN_DEPTH + k;
      q1 = (k << 30) / d;
      r = (k << 30) % d;
      z = (q1 << 30) | ((r << 30) / d);
      z2 = mul_q60(z, z);
      p = z;
      sum = 0;
      for (int n = 0; n < 64 && p != 0; n++) begin
         sum += p / longint'(2 * n + 1);
         p = mul_q60(p, z2);
      end
      return longint'(((2 * sum + (64'd1 << 29)) >> 30) & 64'hffffffff);
   endfunction

   function automatic longint round_shift(longint v, int s);
      logic signed [71:0] w;
      w = 72'(v);
      if (s > 0) w = w + (72'sd1 <<< (s - 1));
      return longint'(w >>> s);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint log_fixed(longint unsigned jv);
      int p;
      longint unsigned f, t, idx, rem, lo, hi;
      longint ln30;
      p = 30;
      while (p > 0 && jv[p] == 1'b0) p--;
      f = (jv << (30 - p)) - (64'd1 << 30);
      t = f * LN_DEPTH;
      idx = t >> 30;
      if (idx >= LN_DEPTH) idx = LN_DEPTH - 1;
      rem = t & ((64'd1 << 30) - 1);
      lo = ln_table[idx];
      hi = ln_table[idx + 1];
      ln30 = longint'(p - FB) * ln_table[LN_DEPTH] + longint'(lo + (((hi - lo) * rem) >> 30));
      return clamp32(round_shift(ln30, 30 - FB));
   endfunction

   // Seven rows per point: stress first, then the tangent rows.
   task automatic queue_point_rows(point_t pt);
      longint bm [3][3];
      longint jv, mj, lj, lnq, t1, t2, p1, p2, a, c;
      int i, j, k, l;
      row_t rw;
      jv = pt.j;
      if (jv == 0) jv = 1;
      for (int n = 0; n < NUM_COLS; n++) begin
         bm[VOIGT_I[n]][VOIGT_J[n]] = longint'(pt.b[n]);
         bm[VOIGT_J[n]][VOIGT_I[n]] = longint'(pt.b[n]);
      end
      mj = clamp32(round_shift(model_mu * jv, FB));
      lj = clamp32(round_shift(model_lam * jv, FB));
      lnq = log_fixed(jv);
      rw.row = ROW_STRESS;
      rw.last = 1'b0;
      for (int n = 0; n < NUM_COLS; n++) begin
         i = VOIGT_I[n]; k = VOIGT_J[n];
         if (i == k) begin
            t1 = clamp32(round_shift(mj * (bm[i][i] - (64'sd1 << FB)), FB));
            t2 = clamp32(round_shift(lj * lnq, FB));
            rw.col[n] = 32'(clamp32(t1 - t2));
         end else begin
            rw.col[n] = 32'(clamp32(round_shift(mj * bm[i][k], FB)));
         end
      end
      expected_rows.push_back(rw);
      for (int r = 0; r < NUM_COLS; r++) begin
         i = VOIGT_I[r]; j = VOIGT_J[r];
         rw.row = 3'(r + 1);
         rw.last = (r == NUM_COLS - 1);
         for (int n = 0; n < NUM_COLS; n++) begin
            k = VOIGT_I[n]; l = VOIGT_J[n];
            p1 = clamp32(round_shift(bm[i][k] * bm[l][j], FB));
            p2 = clamp32(round_shift(bm[i][l] * bm[k][j], FB));
            a = clamp32(round_shift(model_mu * p1 + model_mu * p2, FB + 1));
            c = (i == j) ? clamp32(round_shift(model_lam * bm[k][l], FB + 1)) : 0;
            rw.col[n] = 32'(clamp32(-a - c));
         end
         expected_rows.push_back(rw);
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch at row beat %0d: %s got %0d expected %0d", rows_done, what, got, want);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYC) begin
         $display("neo_hookean_stress_and_tangent_unit regression: fail");
         $finish;
      end
   end

   // Request driver, also randomising rsp_ready.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_points.size() > 0 && $urandom_range(99) >= tx_idle) begin
            point_t pt;
            pt = pending_points.pop_front();
            for (int n = 0; n < NUM_COLS; n++) req_b[n] <= pt.b[n];
            req_inv_jacobian <= pt.j;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= rx_idle);
   end

   // Monitor: predict on accepted requests, check accepted rows.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            point_t pt;
            for (int n = 0; n < NUM_COLS; n++) pt.b[n] = req_b[n];
            pt.j = req_inv_jacobian;
            queue_point_rows(pt);
            points_done++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rows.size() == 0) begin
               report_mismatch("unexpected row beat", rsp_row_index, -1);
            end else begin
               row_t want;
               want = expected_rows.pop_front();
               if (rsp_row_index !== want.row)
                  report_mismatch("row_index", rsp_row_index, want.row);
               for (int n = 0; n < NUM_COLS; n++)
                  if (rsp_col[n] !== want.col[n])
                     report_mismatch($sformatf("column %0d", n), rsp_col[n], want.col[n]);
               if (rsp_last_row !== want.last)
                  report_mismatch("last_row", rsp_last_row, want.last);
            end
            rows_done++;
         end
      end
   end

   task automatic write_csr(logic idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LAME_LAMBDA) model_lam = longint'($signed(value));
      else model_mu = longint'(value[30:0]);
   endtask

   task automatic add_point(logic [31:0] bxx, logic [31:0] byy, logic [31:0] bzz,
                            logic [31:0] bxy, logic [31:0] byz, logic [31:0] bxz,
                            logic [30:0] jv);
      point_t pt;
      pt.b[0] = bxx; pt.b[1] = byy; pt.b[2] = bzz;
      pt.b[3] = bxy; pt.b[4] = byz; pt.b[5] = bxz;
      pt.j = jv;
      pending_points.push_back(pt);
   endtask

   // Mostly physically sensible points near the identity, some raw noise.
   task automatic add_random_points(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(3) == 0) begin
            add_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      31'($urandom));
         end else begin
            add_point(32'h10000 + 32'($signed($urandom_range(65536) - 32768)),
                      32'h10000 + 32'($signed($urandom_range(65536) - 32768)),
                      32'h10000 + 32'($signed($urandom_range(65536) - 32768)),
                      32'($signed($urandom_range(32768) - 16384)),
                      32'($signed($urandom_range(32768) - 16384)),
                      32'($signed($urandom_range(32768) - 16384)),
                      31'($urandom_range(32'h30000, 32'h4000)));
         end
      end
   endtask

   task automatic drain();
      wait (pending_points.size() == 0 && !req_valid);
      wait (expected_rows.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      for (int k = 0; k <= LN_DEPTH; k++) ln_table[k] = ln_point(k);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      tx_idle = 6; rx_idle = 47;

      // Reset values first, with the directed points.
      add_point(32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 31'h10000);
      add_point(0, 0, 0, 0, 0, 0, 31'd0);
      add_point(0, 0, 0, 0, 0, 0, 31'd1);
      add_point(32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 31'h7fffffff);
      add_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 31'h7fffffff);
      add_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 31'h7fffffff);
      add_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 31'd1);
      add_point(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                32'hffffffff, 31'h8000);
      add_point(32'h18000, 32'h8000, 32'h20000, 32'h4000, 32'hffffc000, 32'h2000,
                31'h18000);
      add_point(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000,
                31'h0ffff);
      add_point(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
                32'haaaaaaaa, 31'h2aaaaaaa);
      add_random_points(25);
      drain();

      write_csr(CSR_SHEAR_MODULUS, 32'h7fffffff);
      write_csr(CSR_LAME_LAMBDA, 32'h80000000);
      add_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 31'h7fffffff);
      add_point(32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 31'd0);
      add_random_points(30);
      drain();

      tx_idle = 47; rx_idle = 6;
      write_csr(CSR_SHEAR_MODULUS, 32'h0);
      write_csr(CSR_LAME_LAMBDA, 32'h7fffffff);
      add_random_points(30);
      drain();

      write_csr(CSR_SHEAR_MODULUS, $urandom);
      write_csr(CSR_LAME_LAMBDA, $urandom);
      add_random_points(30);
      drain();

      tx_idle = 0; rx_idle = 0;
      write_csr(CSR_SHEAR_MODULUS, 32'h0000c000);
      write_csr(CSR_LAME_LAMBDA, 32'hffff8000);
      add_random_points(30);
      drain();

      $display("covered %0d material points and %0d row beats over five register settings",
               points_done, rows_done);
      $display("register extremes, zero and full-scale j, saturation and three idle profiles");
      if (errors == 0) begin
         $display("neo_hookean_stress_and_tangent_unit regression: pass");
      end else begin
         $display("neo_hookean_stress_and_tangent_unit regression: fail");
      end
      $finish;
   end

endmodule
